// File: sv/waveform_sequence_sample_lookup_core_macros.svh
// Assertion helpers for the sample lookup core.
// Both forms use the enclosing module's clk and rst_n.
`ifndef WAVEFORM_SEQUENCE_SAMPLE_LOOKUP_CORE_MACROS_SVH
`define WAVEFORM_SEQUENCE_SAMPLE_LOOKUP_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define WSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define WSL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WSL_ASSERT_IMP(lbl, ante, cons, msg)
`define WSL_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/wsl_pkg.sv
package wsl_pkg;

  localparam int ACTION_W  = 2;
  localparam int CHANNEL_W = 5;
  localparam int ENTRY_W   = 4;
  localparam int REPEAT_W  = 16;
  localparam int WAVE_W    = 4;
  localparam int SEGIDX_W  = 6;
  localparam int RUN_W     = 24;
  localparam int LEVEL_W   = 16;
  localparam int SAMPLE_W  = 32;
  localparam int LEN_W     = 32;
  localparam int SPAN_W    = REPEAT_W + LEN_W;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 16;

  // tdata bit offsets
  localparam int OFS_CHANNEL = 0;
  localparam int OFS_ENTRY   = OFS_CHANNEL + CHANNEL_W;
  localparam int OFS_REPEAT  = OFS_ENTRY + ENTRY_W;
  localparam int OFS_WAVE    = OFS_REPEAT + REPEAT_W;
  localparam int OFS_SEGIDX  = OFS_WAVE + WAVE_W;
  localparam int OFS_RUN     = OFS_SEGIDX + SEGIDX_W;
  localparam int OFS_LEVEL   = OFS_RUN + RUN_W;
  localparam int OFS_SAMPLE  = OFS_LEVEL + LEVEL_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENTRY   = 2'd0,
    ACT_SEGMENT = 2'd1,
    ACT_QUERY   = 2'd2
  } action_t;

  typedef struct packed {
    action_t                    kind;
    logic [CHANNEL_W-1:0]       channel;
    logic [ENTRY_W-1:0]         entry_index;
    logic [REPEAT_W-1:0]        repeat_count;
    logic [WAVE_W-1:0]          wave_id;
    logic [SEGIDX_W-1:0]        segment_index;
    logic [RUN_W-1:0]           run_length;
    logic signed [LEVEL_W-1:0]  level;
    logic [SAMPLE_W-1:0]        sample_index;
  } item_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_NEXT,
    BK_EVAL,
    BK_MUL,
    BK_CMP,
    BK_DIV,
    BK_SRCH,
    BK_SRCH_WAIT,
    BK_SRCH_DATA,
    BK_LVL_WAIT,
    BK_LVL,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } bk_stat_t;

endpackage

// File: sv/wsl_ram.sv
module wsl_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/wsl_front.sv
module wsl_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [wsl_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [wsl_pkg::ACTION_W-1:0]   in_tuser,
  output logic                           q_valid,
  output wsl_pkg::item_t                 q_item,
  input  wsl_pkg::bk_stat_t              bk_stat
);
  import wsl_pkg::*;

  localparam int QDEPTH = 2;

  item_t      q_r [QDEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  item_t      in_item;
  logic       keep;
  logic       push;
  logic       pop;

  always_comb begin
    in_item.kind          = action_t'(in_tuser);
    in_item.channel       = in_tdata[OFS_CHANNEL +: CHANNEL_W];
    in_item.entry_index   = in_tdata[OFS_ENTRY +: ENTRY_W];
    in_item.repeat_count  = in_tdata[OFS_REPEAT +: REPEAT_W];
    in_item.wave_id       = in_tdata[OFS_WAVE +: WAVE_W];
    in_item.segment_index = in_tdata[OFS_SEGIDX +: SEGIDX_W];
    in_item.run_length    = in_tdata[OFS_RUN +: RUN_W];
    in_item.level         = in_tdata[OFS_LEVEL +: LEVEL_W];
    in_item.sample_index  = in_tdata[OFS_SAMPLE +: SAMPLE_W];
    // unused action code is taken and dropped
    case (action_t'(in_tuser))
      ACT_ENTRY, ACT_SEGMENT, ACT_QUERY: keep = 1'b1;
      default:                           keep = 1'b0;
    endcase
  end

  assign in_tready = (cnt_r != 2'(QDEPTH));
  assign push      = in_tvalid && in_tready && keep;
  assign pop       = bk_stat.pop;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: sv/wsl_back.sv
module wsl_back #(
  parameter int CHANNELS  = 17,
  parameter int SEQ_DEPTH = 16,
  parameter int WAVES     = 16,
  parameter int SEG_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  wsl_pkg::item_t                  q_item,
  output wsl_pkg::bk_stat_t               bk_stat,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [wsl_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tuser
);
  import wsl_pkg::*;

  localparam int CH_IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = $clog2(SEQ_DEPTH + 1);
  localparam int ENT_N  = CHANNELS * SEQ_DEPTH;
  localparam int ENT_AW = (ENT_N > 1) ? $clog2(ENT_N) : 1;
  localparam int WID_W  = (WAVES > 1) ? $clog2(WAVES) : 1;
  localparam int SCNT_W = $clog2(SEG_DEPTH + 1);
  localparam int SIDX_W = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
  localparam int SEG_N  = WAVES * SEG_DEPTH;
  localparam int SEG_AW = (SEG_N > 1) ? $clog2(SEG_N) : 1;
  localparam int ENT_DW = WAVE_W + REPEAT_W;
  localparam int SEG_DW = LEVEL_W + LEN_W;

  logic [CNT_W-1:0]  entry_count_r [CHANNELS];
  logic [LEN_W-1:0]  wave_length_r [WAVES];
  logic [SCNT_W-1:0] wave_segs_r   [WAVES];

  bk_state_t            state_r, state_nxt;
  logic [CH_IW-1:0]     ch_r;
  logic [CNT_W-1:0]     n_r, e_r;
  logic [SAMPLE_W-1:0]  rem_r;
  logic [REPEAT_W-1:0]  rep_r;
  logic [LEN_W-1:0]     len_r;
  logic [WID_W-1:0]     wave_r;
  logic [SPAN_W-1:0]    span_r;
  logic [4:0]           div_cnt_r;
  logic [LEN_W-1:0]     part_r;
  logic [SAMPLE_W-1:0]  dvd_r;
  logic [SCNT_W-1:0]    lo_r, hi_r;
  logic [SIDX_W-1:0]    sidx_r;
  logic                 res_found_r;
  logic [LEVEL_W-1:0]   res_level_r;
  logic                 out_valid_r;
  logic [LEVEL_W-1:0]   out_data_r;
  logic                 out_found_r;

  // entry and segment stores
  logic                 ent_we;
  logic [ENT_AW-1:0]    ent_waddr, ent_raddr;
  logic [ENT_DW-1:0]    ent_wdata, ent_q;
  logic                 seg_we;
  logic [SEG_AW-1:0]    seg_waddr, seg_raddr;
  logic [SEG_DW-1:0]    seg_wdata, seg_q;

  item_t               h;
  logic                ch_ok, ei_ok, w_ok, s_ok, order_ok;
  logic [SCNT_W-1:0]   cur_segs;
  logic [LEN_W-1:0]    cur_len, seg_start;
  logic [WAVE_W-1:0]   ev_wave;
  logic [LEN_W-1:0]    ev_len;
  logic [LEN_W:0]      trial;
  logic [SCNT_W-1:0]   mid;
  logic                srch_end;
  logic                pop;
  logic                load_out;

  assign h        = q_item;
  assign ch_ok    = 32'(h.channel) < CHANNELS;
  assign ei_ok    = 32'(h.entry_index) < SEQ_DEPTH;
  assign w_ok     = 32'(h.wave_id) < WAVES;
  assign s_ok     = 32'(h.segment_index) < SEG_DEPTH;
  assign cur_segs = wave_segs_r[WID_W'(h.wave_id)];
  assign cur_len  = wave_length_r[WID_W'(h.wave_id)];
  // segments land in order; index zero restarts the wave
  assign order_ok = (h.segment_index == '0) || (32'(h.segment_index) == 32'(cur_segs));
  assign seg_start = (h.segment_index == '0) ? '0 : cur_len;

  assign pop    = (state_r == BK_IDLE) && q_valid;
  assign ent_we = pop && (h.kind == ACT_ENTRY) && ch_ok && ei_ok;
  assign seg_we = pop && (h.kind == ACT_SEGMENT) && w_ok && s_ok && order_ok;

  assign ent_waddr = ENT_AW'(32'(h.channel) * SEQ_DEPTH + 32'(h.entry_index));
  assign ent_wdata = {h.wave_id, h.repeat_count};
  assign ent_raddr = ENT_AW'(32'(ch_r) * SEQ_DEPTH + 32'(e_r));
  assign seg_waddr = SEG_AW'(32'(h.wave_id) * SEG_DEPTH + 32'(h.segment_index));
  assign seg_wdata = {h.level, seg_start};
  assign seg_raddr = SEG_AW'(32'(wave_r) * SEG_DEPTH + 32'(sidx_r));

  wsl_ram #(.W(ENT_DW), .DEPTH(ENT_N)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_q)
  );

  wsl_ram #(.W(SEG_DW), .DEPTH(SEG_N)) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (seg_waddr),
    .wdata (seg_wdata),
    .raddr (seg_raddr),
    .rdata (seg_q)
  );

  assign ev_wave  = ent_q[REPEAT_W +: WAVE_W];
  assign ev_len   = (32'(ev_wave) < WAVES) ? wave_length_r[WID_W'(ev_wave)] : '0;
  assign trial    = {part_r, dvd_r[SAMPLE_W-1]};
  assign mid      = SCNT_W'((32'(lo_r) + 32'(hi_r)) >> 1);
  assign srch_end = (hi_r - lo_r) <= SCNT_W'(1);
  assign load_out = (state_r == BK_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:      if (pop && h.kind == ACT_QUERY) state_nxt = BK_NEXT;
      BK_NEXT:      state_nxt = (e_r < n_r) ? BK_EVAL : BK_DONE;
      BK_EVAL:      state_nxt = BK_MUL;
      BK_MUL:       state_nxt = BK_CMP;
      BK_CMP: begin
        if (span_r != '0 && SPAN_W'(rem_r) < span_r) state_nxt = BK_DIV;
        else state_nxt = BK_NEXT;
      end
      BK_DIV:       if (div_cnt_r == 5'd31) state_nxt = BK_SRCH;
      BK_SRCH:      state_nxt = srch_end ? BK_LVL_WAIT : BK_SRCH_WAIT;
      BK_SRCH_WAIT: state_nxt = BK_SRCH_DATA;
      BK_SRCH_DATA: state_nxt = BK_SRCH;
      BK_LVL_WAIT:  state_nxt = BK_LVL;
      BK_LVL:       state_nxt = BK_DONE;
      BK_DONE:      if (load_out) state_nxt = BK_IDLE;
      default:      state_nxt = BK_IDLE;
    endcase
    bk_stat.busy = (state_r != BK_IDLE);
    bk_stat.pop  = pop;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        ch_r  <= CH_IW'(h.channel);
        n_r   <= ch_ok ? entry_count_r[CH_IW'(h.channel)] : '0;
        e_r   <= '0;
        rem_r <= h.sample_index;
        res_found_r <= 1'b0;
        res_level_r <= '0;
      end
      BK_EVAL: begin
        rep_r  <= ent_q[REPEAT_W-1:0];
        len_r  <= ev_len;
        wave_r <= WID_W'(ev_wave);
      end
      BK_MUL: span_r <= SPAN_W'(rep_r) * SPAN_W'(len_r);
      BK_CMP: begin
        if (span_r != '0 && SPAN_W'(rem_r) < span_r) begin
          part_r    <= '0;
          dvd_r     <= rem_r;
          div_cnt_r <= '0;
        end else begin
          rem_r <= rem_r - SAMPLE_W'(span_r);
          e_r   <= e_r + CNT_W'(1);
        end
      end
      BK_DIV: begin
        // restoring remainder, one bit per cycle
        if (trial >= {1'b0, len_r}) part_r <= LEN_W'(trial - {1'b0, len_r});
        else part_r <= trial[LEN_W-1:0];
        dvd_r     <= dvd_r << 1;
        div_cnt_r <= div_cnt_r + 5'd1;
        lo_r      <= '0;
        hi_r      <= wave_segs_r[wave_r];
      end
      BK_SRCH: sidx_r <= srch_end ? SIDX_W'(lo_r) : SIDX_W'(mid);
      BK_SRCH_DATA: begin
        // last segment whose start is at or below the offset
        if (seg_q[LEN_W-1:0] <= part_r) lo_r <= SCNT_W'(sidx_r);
        else hi_r <= SCNT_W'(sidx_r);
      end
      BK_LVL: begin
        res_found_r <= 1'b1;
        res_level_r <= seg_q[LEN_W +: LEVEL_W];
      end
      default: ;
    endcase

    if (seg_we) begin
      wave_length_r[WID_W'(h.wave_id)] <= seg_start + LEN_W'(h.run_length);
      wave_segs_r[WID_W'(h.wave_id)]   <= SCNT_W'(32'(h.segment_index) + 1);
    end
    if (ent_we) begin
      entry_count_r[CH_IW'(h.channel)] <= CNT_W'(32'(h.entry_index) + 1);
    end
    if (load_out) begin
      out_data_r  <= res_level_r;
      out_found_r <= res_found_r;
    end

    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) entry_count_r[i] <= '0;
      for (int i = 0; i < WAVES; i++) begin
        wave_length_r[i] <= '0;
        wave_segs_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;

endmodule

// File: sv/waveform_sequence_sample_lookup_core.sv
// channel | dir | tdata (low bit up)                              | tuser
// in_     | in  | channel, entry_index, repeat_count, wave_id,   | action
//         |     | segment_index, run_length, level, sample_index |
// out_    | out | sample_value                                    | found
//
// Writes (entry or segment) retire as soon as the back end pops them.
// A query walks the sequence entries until one covers the sample, then finds the
// offset remainder (bit-serial divider) and the segment by binary search.
// A two-deep queue takes items while the back end is busy; the result
// register holds one answer under out_tready backpressure.
// Reset (rst_n low, synchronous) clears counts and wave totals.
`include "waveform_sequence_sample_lookup_core_macros.svh"

module waveform_sequence_sample_lookup_core #(
  parameter int CHANNELS  = 17,
  parameter int SEQ_DEPTH = 16,
  parameter int WAVES     = 16,
  parameter int SEG_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // channel, entry_index, repeat_count, wave_id, segment_index, run_length,
  // level, sample_index, zero pad
  input  logic [wsl_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [wsl_pkg::ACTION_W-1:0]    in_tuser,   // action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [wsl_pkg::OUT_DATA_W-1:0]  out_tdata,  // sample_value
  output logic                            out_tuser   // found
);
  import wsl_pkg::*;

  logic     q_valid;
  item_t    q_item;
  bk_stat_t bk_stat;

  wsl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .bk_stat   (bk_stat)
  );

  wsl_back #(
    .CHANNELS  (CHANNELS),
    .SEQ_DEPTH (SEQ_DEPTH),
    .WAVES     (WAVES),
    .SEG_DEPTH (SEG_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .bk_stat    (bk_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  `WSL_ASSERT_IMP(a_miss_zero, out_tvalid && !out_tuser, out_tdata == '0, "miss with nonzero value")
  `WSL_ASSERT_IMP(a_res_src, $rose(out_tvalid), $past(bk_stat.busy), "result without query")
  `WSL_ASSERT_IMP(a_pop_valid, bk_stat.pop, q_valid, "pop from empty queue")

endmodule

// File: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsl_pkg::*;

  localparam int NCH = 17;
  localparam int NSEQ = 16;
  localparam int NWAVE = 16;
  localparam int NSEG = 64;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [1:0] ACT_RSVD = 2'd3;

  // expected lookup answers, oldest first
  class lookup_scoreboard;
    logic [15:0] rep_tab [NCH*NSEQ];
    logic [3:0]  wav_tab [NCH*NSEQ];
    int unsigned cnt_tab [NCH];
    logic [31:0] seg_start [NWAVE*NSEG];
    logic [15:0] seg_level [NWAVE*NSEG];
    logic [31:0] wave_len [NWAVE];
    int unsigned wave_segs [NWAVE];
    logic [15:0] exp_value [$];
    bit          exp_found [$];
    int          errors;

    function void clear();
      foreach (cnt_tab[i]) cnt_tab[i] = 0;
      foreach (wave_len[i]) wave_len[i] = 0;
      foreach (wave_segs[i]) wave_segs[i] = 0;
      errors = 0;
    endfunction

    function void note_item(action_t act, item_t it);
      int unsigned slot, w, n, pick;
      longint unsigned base, span, len, off;
      bit hit;
      logic [15:0] lv;
      case (act)
        ACT_ENTRY: begin
          if (it.channel < NCH) begin
            slot = it.channel * NSEQ + it.entry_index;
            rep_tab[slot] = it.repeat_count;
            wav_tab[slot] = it.wave_id;
            cnt_tab[it.channel] = it.entry_index + 1;
          end
        end
        ACT_SEGMENT: begin
          w = it.wave_id;
          if (it.segment_index == 0) begin
            wave_len[w] = 0;
            wave_segs[w] = 0;
          end
          if (it.segment_index == wave_segs[w]) begin
            slot = w * NSEG + it.segment_index;
            seg_start[slot] = wave_len[w];
            seg_level[slot] = it.level;
            wave_segs[w] = it.segment_index + 1;
            wave_len[w] = wave_len[w] + 32'(it.run_length);
          end
        end
        ACT_QUERY: begin
          hit = 0;
          lv = 0;
          base = 0;
          if (it.channel < NCH) begin
            n = cnt_tab[it.channel];
            for (int e = 0; e < n && !hit; e++) begin
              slot = it.channel * NSEQ + e;
              w = wav_tab[slot];
              len = wave_len[w];
              span = longint'(rep_tab[slot]) * len;
              if (span != 0 && it.sample_index < base + span) begin
                off = (it.sample_index - base) % len;
                pick = 0;
                for (int s = 0; s < wave_segs[w]; s++)
                  if (seg_start[w*NSEG+s] <= off) pick = s;
                lv = seg_level[w*NSEG+pick];
                hit = 1;
              end
              base += span;
            end
          end
          exp_value = {exp_value, lv};
          exp_found = {exp_found, hit};
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [15:0] value, logic fnd);
      if (exp_value.size() == 0) begin
        $error("unexpected result value=%0d found=%0b", $signed(value), fnd);
        errors++;
        return;
      end
      if (fnd !== exp_found[0]) begin
        $error("found: expected %0b, got %0b", exp_found[0], fnd);
        errors++;
      end
      if (value !== exp_value[0]) begin
        $error("sample_value: expected %0d, got %0d", $signed(exp_value[0]), $signed(value));
        errors++;
      end
      void'(exp_value.pop_front());
      void'(exp_found.pop_front());
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [ACTION_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;

  lookup_scoreboard sb = new();
  int cycles = 0;
  bit calm = 0;       // no idling on either side
  bit hold_off = 0;   // receiver stalls for a long stretch
  int unsigned ent_cnt [NCH];

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  waveform_sequence_sample_lookup_core i_dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    out_tready <= !hold_off && (calm || $urandom_range(99) >= 23);
  end

  task automatic send_item(logic [1:0] act, item_t it);
    while (!calm && $urandom_range(99) < 23) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= act;
    in_tdata <= {5'b0, it.sample_index, it.level, it.run_length, it.segment_index,
                 it.wave_id, it.repeat_count, it.entry_index, it.channel};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(action_t'(act), it);
  endtask

  function automatic item_t rand_item();
    item_t it;
    it.kind = ACT_ENTRY;
    it.channel = 5'($urandom_range(NCH - 1));
    it.entry_index = 4'($urandom);
    it.repeat_count = 16'($urandom);
    it.wave_id = 4'($urandom);
    it.segment_index = 6'($urandom);
    it.run_length = 24'($urandom);
    it.level = 16'($urandom);
    it.sample_index = $urandom;
    return it;
  endfunction

  // entry writes never leave an unwritten entry below the count
  task automatic write_entry(item_t it);
    if (it.channel < NCH) begin
      if (it.entry_index > ent_cnt[it.channel]) it.entry_index = 4'(ent_cnt[it.channel]);
      if (it.entry_index + 1 > ent_cnt[it.channel] || 1)
        ent_cnt[it.channel] = it.entry_index + 1;
    end
    send_item(ACT_ENTRY, it);
  endtask

  task automatic build_wave(int w, int nseg, int maxrun);
    item_t it;
    for (int s = 0; s < nseg; s++) begin
      it = rand_item();
      it.wave_id = 4'(w);
      it.segment_index = 6'(s);
      it.run_length = 24'($urandom_range(maxrun));
      send_item(ACT_SEGMENT, it);
    end
  endtask

  task automatic query(int ch, logic [31:0] idx);
    item_t it;
    it = rand_item();
    it.channel = 5'(ch);
    it.sample_index = idx;
    send_item(ACT_QUERY, it);
  endtask

  initial begin
    item_t it;
    int n, r, drain;
    sb.clear();
    foreach (ent_cnt[i]) ent_cnt[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty channel, out-of-range channel, extremes
    query(0, 0);
    query(31, 32'hFFFF_FFFF);
    it = rand_item(); send_item(ACT_RSVD, it);
    it = rand_item(); it.channel = 5'd20; send_item(ACT_ENTRY, it);
    build_wave(0, 3, 10);
    it = rand_item(); it.wave_id = 4'd0; it.segment_index = 6'd7; send_item(ACT_SEGMENT, it);
    it = rand_item(); it.wave_id = 4'd1; it.segment_index = 6'd0; it.run_length = 24'hFFFFFF;
    it.level = 16'sh8000; send_item(ACT_SEGMENT, it);
    it.segment_index = 6'd1; it.run_length = 24'd0; it.level = 16'sh7FFF;
    send_item(ACT_SEGMENT, it);
    it.segment_index = 6'd2; it.run_length = 24'd5; send_item(ACT_SEGMENT, it);
    it = rand_item(); it.channel = 5'd16; it.entry_index = 4'd0; it.repeat_count = 16'd0;
    it.wave_id = 4'd0; write_entry(it);
    it.entry_index = 4'd1; it.repeat_count = 16'hFFFF; it.wave_id = 4'd1; write_entry(it);
    it.entry_index = 4'd2; it.repeat_count = 16'd2; it.wave_id = 4'd0; write_entry(it);
    query(16, 0);
    query(16, 32'h00FF_FFFF);
    query(16, 32'hFFFF_FFFF);
    query(16, 32'h0100_0003);

    // random: mostly queries into the sequences, mixed with waves, entries, stray segments and reserved actions
    for (int i = 0; i < 540; i++) begin
      if (i == 60) calm = 1;
      if (i == 160) calm = 0;
      if (i == 300) begin
        hold_off = 1;
        fork begin repeat (400) @(posedge clk); hold_off = 0; end join_none
      end
      r = $urandom_range(99);
      if (r < 12) begin
        build_wave($urandom_range(NWAVE - 1), $urandom_range(1, 6),
                   ($urandom_range(3) == 0) ? 24'hFFFFFF : 40);
        i += 3;
      end else if (r < 30) begin
        it = rand_item();
        if ($urandom_range(3) != 0) it.repeat_count = 16'($urandom_range(4));
        write_entry(it);
      end else if (r < 34) begin
        it = rand_item();
        if ($urandom_range(1)) it.segment_index = 6'(60 + $urandom_range(3));
        send_item(ACT_SEGMENT, it);
      end else if (r < 36) begin
        it = rand_item(); send_item(ACT_RSVD, it);
      end else if (r < 38) begin
        it = rand_item(); query($urandom_range(17, 31), it.sample_index);
      end else begin
        n = $urandom_range(NCH - 1);
        it = rand_item();
        query(n, ($urandom_range(3) == 0) ? it.sample_index : $urandom_range(600));
      end
    end
    in_tvalid <= 0;

    while (sb.exp_value.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    if (sb.errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end
endmodule
